// ===== src/graph_bfs_order_defines.svh =====
// assertion macros for the breadth-first walk block
// used by graph_bfs_order; expects clk and rst_n in scope
`ifndef GRAPH_BFS_ORDER_DEFINES_SVH
`define GRAPH_BFS_ORDER_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define GBFS_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that holds in the cycle after the antecedent
`define GBFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/gbfs_pkg.sv =====
// shared types, constants and helpers for the breadth-first walk block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gbfs_pkg;

    localparam int NUM_VERTICES = 16;
    localparam int VTX_W        = 5;
    localparam int IDX_W        = $clog2(NUM_VERTICES);
    localparam int CNT_W        = IDX_W + 1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic [VTX_W-1:0]        vertex;
        logic [NUM_VERTICES-1:0] row_mask;
    } item_t;

    typedef struct packed {
        logic [VTX_W-1:0] visited_vertex;
        logic             last;
    } result_t;

    typedef struct packed {
        logic                    we;
        logic [IDX_W-1:0]        waddr;
        logic [NUM_VERTICES-1:0] wdata;
        logic [IDX_W-1:0]        raddr;
    } adj_req_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [VTX_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } vq_req_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] head;
        logic [CNT_W-1:0] tail;
    } status_t;

    function automatic logic vertex_ok(input logic [VTX_W-1:0] v);
        return (v != '0) && (v <= VTX_W'(NUM_VERTICES));
    endfunction

    function automatic logic [IDX_W-1:0] lowest_index(input logic [NUM_VERTICES-1:0] mask);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = NUM_VERTICES - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== src/graph_bfs_order.sv =====
// graph_bfs_order: breadth-first visit order over a 16-vertex adjacency matrix
// a load request writes one adjacency row; a start request emits one vertex per visit,
// each visit stepping through queue read, row read, candidate mask, a scan that queues
// each new neighbour, and emit; the queue and row memories have registered reads
// reset clears the sequencer, visited mask and queue pointers; rows stay undefined
// depends on gbfs_pkg, gbfs_adj_store, gbfs_vqueue, gbfs_walk
`timescale 1ns / 1ps
`default_nettype none
`include "graph_bfs_order_defines.svh"

module graph_bfs_order (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire gbfs_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output gbfs_pkg::result_t      result
);
    import gbfs_pkg::*;

    adj_req_t                adj_req;
    logic [NUM_VERTICES-1:0] adj_rdata;
    vq_req_t                 vq_req;
    logic [VTX_W-1:0]        vq_rdata;
    status_t                 status;
    logic                    emit_valid;
    logic                    emit_ready;
    result_t                 emit;

    logic    result_valid_reg;
    result_t result_reg;

    gbfs_adj_store u_adj_store (
        .clk   (clk),
        .req   (adj_req),
        .rdata (adj_rdata)
    );

    gbfs_vqueue u_vqueue (
        .clk   (clk),
        .req   (vq_req),
        .rdata (vq_rdata)
    );

    gbfs_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit       (emit),
        .adj_req    (adj_req),
        .adj_rdata  (adj_rdata),
        .vq_req     (vq_req),
        .vq_rdata   (vq_rdata),
        .status     (status)
    );

    // output register
    assign emit_ready = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit_valid && emit_ready)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid && emit_ready)
        begin
            result_reg <= emit;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `GBFS_ASSERT_HOLDS(a_queue_bounds, (status.head <= status.tail) && (status.tail <= CNT_W'(NUM_VERTICES)), "queue pointers out of order")
    `GBFS_ASSERT_NEXT(a_last_ends_walk, emit_valid && emit_ready && emit.last, item_ready, "walk still busy after last vertex")
    `GBFS_ASSERT_NEXT(a_start_seeds_queue, item_valid && item_ready && (item.kind == KIND_START) && (item.vertex != '0) && (item.vertex <= VTX_W'(NUM_VERTICES)), status.busy && (status.head == '0) && (status.tail == CNT_W'(1)), "start request did not seed the queue")

endmodule

`default_nettype wire

// ===== src/gbfs_adj_store.sv =====
// adjacency row memory, one row per vertex, one write and one registered read
// depends on gbfs_pkg
`timescale 1ns / 1ps
`default_nettype none

module gbfs_adj_store (
    input  wire logic                               clk,
    input  wire gbfs_pkg::adj_req_t                 req,
    output logic [gbfs_pkg::NUM_VERTICES-1:0]       rdata
);
    import gbfs_pkg::*;

    logic [NUM_VERTICES-1:0] mem [NUM_VERTICES];
    logic [NUM_VERTICES-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/gbfs_vqueue.sv =====
// vertex queue memory, written at the tail and read at the head
// depends on gbfs_pkg
`timescale 1ns / 1ps
`default_nettype none

module gbfs_vqueue (
    input  wire logic                        clk,
    input  wire gbfs_pkg::vq_req_t           req,
    output logic [gbfs_pkg::VTX_W-1:0]       rdata
);
    import gbfs_pkg::*;

    logic [VTX_W-1:0] mem [NUM_VERTICES];
    logic [VTX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/gbfs_walk.sv =====
// sequencer for row loads and the breadth-first walk, holds the visited mask
// depends on gbfs_pkg; drives gbfs_adj_store and gbfs_vqueue
`timescale 1ns / 1ps
`default_nettype none

module gbfs_walk (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire gbfs_pkg::item_t                   item,
    output logic                                   emit_valid,
    input  wire logic                              emit_ready,
    output gbfs_pkg::result_t                      emit,
    output gbfs_pkg::adj_req_t                     adj_req,
    input  wire logic [gbfs_pkg::NUM_VERTICES-1:0] adj_rdata,
    output gbfs_pkg::vq_req_t                      vq_req,
    input  wire logic [gbfs_pkg::VTX_W-1:0]        vq_rdata,
    output gbfs_pkg::status_t                      status
);
    import gbfs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_QREAD = 3'd1;
    localparam logic [2:0] ST_AREAD = 3'd2;
    localparam logic [2:0] ST_CAND  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]              state_reg,   state_next;
    logic [NUM_VERTICES-1:0] visited_reg, visited_next;
    logic [NUM_VERTICES-1:0] cand_reg,    cand_next;
    logic [CNT_W-1:0]        head_reg,    head_next;
    logic [CNT_W-1:0]        tail_reg,    tail_next;
    logic [VTX_W-1:0]        cur_reg,     cur_next;

    logic             start_fire;
    logic             load_fire;
    logic [VTX_W-1:0] item_m1;
    logic [VTX_W-1:0] q_m1;
    logic [IDX_W-1:0] low_idx;
    logic [VTX_W-1:0] new_vtx;
    logic             scan_push;

    assign item_ready = (state_reg == ST_IDLE);
    assign start_fire = item_valid && item_ready && (item.kind == KIND_START)
                        && vertex_ok(item.vertex);
    assign load_fire  = item_valid && item_ready && (item.kind == KIND_LOAD)
                        && vertex_ok(item.vertex);
    assign item_m1    = item.vertex - VTX_W'(1);
    assign q_m1       = vq_rdata - VTX_W'(1);
    assign low_idx    = lowest_index(cand_reg);
    assign new_vtx    = VTX_W'(low_idx) + VTX_W'(1);
    assign scan_push  = (state_reg == ST_SCAN) && (cand_reg != '0);

    // memory requests
    always_comb
    begin
        adj_req.we    = load_fire;
        adj_req.waddr = item_m1[IDX_W-1:0];
        adj_req.wdata = item.row_mask;
        adj_req.raddr = q_m1[IDX_W-1:0];

        vq_req.we     = start_fire || scan_push;
        vq_req.waddr  = start_fire ? '0 : tail_reg[IDX_W-1:0];
        vq_req.wdata  = start_fire ? item.vertex : new_vtx;
        vq_req.raddr  = head_reg[IDX_W-1:0];
    end

    assign emit_valid          = (state_reg == ST_EMIT);
    assign emit.visited_vertex = cur_reg;
    assign emit.last           = (head_reg == tail_reg);

    assign status.busy = (state_reg != ST_IDLE);
    assign status.head = head_reg;
    assign status.tail = tail_reg;

    always_comb
    begin
        state_next   = state_reg;
        visited_next = visited_reg;
        cand_next    = cand_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cur_next     = cur_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_fire)
                begin
                    visited_next = NUM_VERTICES'(1) << item_m1[IDX_W-1:0];
                    head_next    = '0;
                    tail_next    = CNT_W'(1);
                    state_next   = ST_QREAD;
                end
            end
            ST_QREAD:
            begin
                state_next = ST_AREAD;
            end
            ST_AREAD:
            begin
                cur_next   = vq_rdata;
                head_next  = head_reg + CNT_W'(1);
                state_next = ST_CAND;
            end
            ST_CAND:
            begin
                // new neighbours are all marked now, queued in ascending order below
                cand_next    = adj_rdata & ~visited_reg;
                visited_next = visited_reg | adj_rdata;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_push)
                begin
                    tail_next = tail_reg + CNT_W'(1);
                    cand_next = cand_reg & (cand_reg - NUM_VERTICES'(1));
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_ready)
                begin
                    state_next = (head_reg == tail_reg) ? ST_IDLE : ST_QREAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            visited_reg <= '0;
            cand_reg    <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            visited_reg <= visited_next;
            cand_reg    <= cand_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

`default_nettype wire
